@@ design/arp_pkg.sv @@
// Package for the ARM relocation patcher: relocation type and status codes,
// configuration register indexes, encoding constants and shared structs.
// Has no dependencies; all design files but arp_checker use it by scoped names.
`default_nettype none

package arp_pkg;

    // Relocation types.
    localparam logic [4:0] KIND_NONE       = 5'd0;
    localparam logic [4:0] KIND_PC24       = 5'd1;
    localparam logic [4:0] KIND_CALL       = 5'd2;
    localparam logic [4:0] KIND_JUMP24     = 5'd3;
    localparam logic [4:0] KIND_PLT32      = 5'd4;
    localparam logic [4:0] KIND_THM_PC22   = 5'd5;
    localparam logic [4:0] KIND_THM_JUMP24 = 5'd6;
    localparam logic [4:0] KIND_MOVT       = 5'd7;
    localparam logic [4:0] KIND_MOVW       = 5'd8;
    localparam logic [4:0] KIND_THM_MOVT   = 5'd9;
    localparam logic [4:0] KIND_THM_MOVW   = 5'd10;
    localparam logic [4:0] KIND_PREL31     = 5'd11;
    localparam logic [4:0] KIND_ABS32      = 5'd12;
    localparam logic [4:0] KIND_REL32      = 5'd13;
    localparam logic [4:0] KIND_GOTPC      = 5'd14;
    localparam logic [4:0] KIND_GOTOFF     = 5'd15;
    localparam logic [4:0] KIND_GOT32      = 5'd16;
    localparam logic [4:0] KIND_COPY       = 5'd17;
    localparam logic [4:0] KIND_V4BX       = 5'd18;
    localparam logic [4:0] KIND_GLOB_DAT   = 5'd19;
    localparam logic [4:0] KIND_JUMP_SLOT  = 5'd20;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_STUB    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BLX_AVAILABLE = 2'd0;
    localparam logic [1:0] CFG_GOT_BASE      = 2'd1;
    localparam logic [1:0] CFG_PLT_BASE      = 2'd2;
    localparam logic [1:0] CFG_PLT_SIZE      = 2'd3;

    // Instruction encoding constants.
    localparam logic [7:0]  ARM_BL_OPCODE   = 8'heb;
    localparam logic [7:0]  ARM_BLX_OPCODE  = 8'hfa;
    localparam logic [31:0] ARM_RANGE_BIAS  = 32'h0200_0000;
    localparam logic [31:0] THM_RANGE_BIAS  = 32'h0100_0000;
    localparam logic [31:0] V4BX_MASK       = 32'h0fff_fff0;
    localparam logic [31:0] V4BX_MATCH      = 32'h012f_ff10;
    localparam logic [31:0] V4BX_BX         = 32'he12f_ff10;
    localparam logic [31:0] V4BX_MOV_PC     = 32'he1a0_f000;

    typedef struct packed {
        logic        blx_available;
        logic [31:0] got_base;
        logic [31:0] plt_base;
        logic [23:0] plt_size;
    } t_cfg;

    // One registered relocation request with its precomputed terms.
    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] word;
        logic [31:0] target;
        logic [31:0] place;
        logic [31:0] got_disp;
        logic        weak_undefined;
        logic [31:0] diff;
        logic        to_plt;
    } t_req;

endpackage

`default_nettype wire

@@ design/arm_relocation_patcher.sv @@
// ARM relocation patcher. A request is captured in the input register, and its
// result is offered from the result register. Throughput: one request per cycle;
// the input register and the result register form a two-stage pipeline that
// advances whenever the result side is not stalled.
// Reset (synchronous, active low) empties both stages and loads the configuration
// defaults: BLX available, GOT base, PLT base and PLT size zero.
`default_nettype none

module arm_relocation_patcher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    // Request channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [4:0]  i_kind,
    input  wire logic [31:0] i_word,
    input  wire logic [31:0] i_target,
    input  wire logic [31:0] i_place,
    input  wire logic [31:0] i_got_disp,
    input  wire logic        i_weak_undefined,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_new_word,
    output logic [1:0]       o_status
);

    arp_pkg::t_cfg r_cfg;
    arp_pkg::t_req r_req;
    arp_pkg::t_req n_req;
    logic          r_in_valid;
    logic          r_out_valid;
    logic [31:0]   r_new_word;
    logic [1:0]    r_status;
    logic [31:0]   n_new_word;
    logic [1:0]    n_status;
    logic          adv_out;
    logic          adv_in;
    logic [32:0]   plt_end;

    // Configuration registers. The user must write only while the pipeline is empty; the block does not check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blx_available <= 1'b1;
            r_cfg.got_base      <= 32'd0;
            r_cfg.plt_base      <= 32'd0;
            r_cfg.plt_size      <= 24'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arp_pkg::CFG_BLX_AVAILABLE: r_cfg.blx_available <= i_cfg_data[0];
                arp_pkg::CFG_GOT_BASE:      r_cfg.got_base      <= i_cfg_data;
                arp_pkg::CFG_PLT_BASE:      r_cfg.plt_base      <= i_cfg_data;
                arp_pkg::CFG_PLT_SIZE:      r_cfg.plt_size      <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // The result register moves on when it is empty or its result is taken, and
    // the input register moves on when it is empty or its request moves ahead.
    // So a new request is taken even while a finished result waits, as long as
    // the input register is empty.
    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv_in     = !r_in_valid || adv_out;
    assign o_in_stall = !adv_in;

    // Stage one also precomputes the PC-relative difference and the PLT range
    // test, so the second stage need not compute them.
    assign plt_end = {1'b0, r_cfg.plt_base} + {9'd0, r_cfg.plt_size};

    always_comb begin
        n_req.kind           = i_kind;
        n_req.word           = i_word;
        n_req.target         = i_target;
        n_req.place          = i_place;
        n_req.got_disp       = i_got_disp;
        n_req.weak_undefined = i_weak_undefined;
        n_req.diff           = i_target - i_place;
        n_req.to_plt         = (i_target >= r_cfg.plt_base) && ({1'b0, i_target} < plt_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_in_valid) begin
            r_req <= n_req;
        end
    end

    arp_core u_core (
        .i_req      (r_req),
        .i_cfg      (r_cfg),
        .o_new_word (n_new_word),
        .o_status   (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_in_valid) begin
            r_new_word <= n_new_word;
            r_status   <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_new_word  = r_new_word;
    assign o_status    = r_status;

endmodule

`default_nettype wire

@@ design/arp_arm_br.sv @@
// ARM B/BL/BLX branch relocation: decode, rebase, check and re-encode.
// Depends on arp_pkg for codes and constants.
`default_nettype none

module arp_arm_br (
    input  wire logic [4:0]  i_kind,
    input  wire logic [31:0] i_word,
    input  wire logic [31:0] i_target,
    input  wire logic [31:0] i_diff,
    input  wire logic        i_blx_available,
    output logic [31:0]      o_word,
    output logic [1:0]       o_status
);

    logic [31:0] off;
    logic [31:0] x;
    logic [31:0] biased;
    logic        is_bl;
    logic        is_call;
    logic        bad_align;
    logic        out_of_range;

    assign off     = {{6{i_word[23]}}, i_word[23:0], 2'b00};
    assign x       = off + i_diff;
    assign is_bl   = (i_word[31:24] == arp_pkg::ARM_BL_OPCODE);
    assign is_call = (i_kind == arp_pkg::KIND_CALL) || ((i_kind == arp_pkg::KIND_PC24) && is_bl);

    // A misaligned offset is fine only for a call that can become BLX.
    assign bad_align    = (x[1:0] != 2'b00) && (!i_blx_available || !is_call);
    assign biased       = x + arp_pkg::ARM_RANGE_BIAS;
    assign out_of_range = (biased[31:26] != 6'd0);

    assign o_status = (bad_align || out_of_range) ? arp_pkg::ST_RANGE : arp_pkg::ST_OK;

    // A Thumb target turns the branch into BLX, with the halfword bit in H (bit 24).
    assign o_word = i_target[0] ? {arp_pkg::ARM_BLX_OPCODE[7:1], x[1], x[25:2]}
                                : {i_word[31:24], x[25:2]};

endmodule

`default_nettype wire

@@ design/arp_thm_br.sv @@
// Thumb BL/B.W pair relocation with J1/J2 offset encoding and BLX conversion.
// Depends on arp_pkg for status codes and constants.
`default_nettype none

module arp_thm_br (
    input  wire logic        i_is_call,
    input  wire logic [31:0] i_word,
    input  wire logic [31:0] i_target,
    input  wire logic [31:0] i_diff,
    input  wire logic        i_to_plt,
    output logic [31:0]      o_word,
    output logic [1:0]       o_status
);

    logic [15:0] hi;
    logic [15:0] lo;
    logic        s;
    logic        i1;
    logic        i2;
    logic [31:0] off;
    logic [31:0] sum;
    logic [31:0] x;
    logic [31:0] biased;
    logic        to_arm_call;
    logic        need_stub;
    logic        out_of_range;
    logic        arm_bad;
    logic        j1;
    logic        j2;

    assign hi  = i_word[15:0];
    assign lo  = i_word[31:16];
    assign s   = hi[10];
    assign i1  = ~(lo[13] ^ s);
    assign i2  = ~(lo[11] ^ s);
    assign off = {{7{s}}, s, i1, i2, hi[9:0], lo[10:0], 1'b0};
    assign sum = off + i_diff;

    // A call into ARM code becomes BLX, whose offset is rounded up to a word.
    assign to_arm_call = !i_target[0] && i_is_call;
    assign x           = to_arm_call ? ((sum + 32'd3) & 32'hffff_fffc) : sum;

    assign biased       = x + arp_pkg::THM_RANGE_BIAS;
    assign out_of_range = (biased[31:25] != 7'd0);
    assign need_stub    = !i_target[0] && !i_to_plt && !i_is_call;
    assign arm_bad      = !i_target[0] && (i_target[1] || (!i_is_call && !i_to_plt));

    always_comb begin
        if (need_stub) begin
            o_status = arp_pkg::ST_STUB;
        end else if (out_of_range || arm_bad) begin
            o_status = arp_pkg::ST_RANGE;
        end else begin
            o_status = arp_pkg::ST_OK;
        end
    end

    assign j1 = x[24] ^ ~x[23];
    assign j2 = x[24] ^ ~x[22];

    assign o_word = {lo[15:14], j1, ~to_arm_call, j2, x[11:1],
                     hi[15:11], x[24], x[21:12]};

endmodule

`default_nettype wire

@@ design/arp_core.sv @@
// Relocation datapath: selects the patch operation by relocation type.
// Depends on arp_pkg, arp_arm_br and arp_thm_br.
`default_nettype none

module arp_core (
    input  wire arp_pkg::t_req i_req,
    input  wire arp_pkg::t_cfg i_cfg,
    output logic [31:0]        o_new_word,
    output logic [1:0]         o_status
);

    logic [31:0] arm_word;
    logic [1:0]  arm_status;
    logic [31:0] thm_word;
    logic [1:0]  thm_status;
    logic [15:0] mov_val;
    logic [31:0] arm_mov_imm;
    logic [31:0] thm_mov_imm;
    logic [31:0] prel;
    logic [31:0] w;
    logic [1:0]  st;

    arp_arm_br u_arm_br (
        .i_kind          (i_req.kind),
        .i_word          (i_req.word),
        .i_target        (i_req.target),
        .i_diff          (i_req.diff),
        .i_blx_available (i_cfg.blx_available),
        .o_word          (arm_word),
        .o_status        (arm_status)
    );

    arp_thm_br u_thm_br (
        .i_is_call (i_req.kind == arp_pkg::KIND_THM_PC22),
        .i_word    (i_req.word),
        .i_target  (i_req.target),
        .i_diff    (i_req.diff),
        .i_to_plt  (i_req.to_plt),
        .o_word    (thm_word),
        .o_status  (thm_status)
    );

    // MOVT takes the upper half of the target, MOVW the lower.
    assign mov_val = ((i_req.kind == arp_pkg::KIND_MOVT) || (i_req.kind == arp_pkg::KIND_THM_MOVT))
                     ? i_req.target[31:16] : i_req.target[15:0];
    assign arm_mov_imm = {12'd0, mov_val[15:12], 4'd0, mov_val[11:0]};
    assign thm_mov_imm = {1'b0, mov_val[10:8], 4'd0, mov_val[7:0], 5'd0, mov_val[11],
                          6'd0, mov_val[15:12]};

    assign prel = {i_req.word[30], i_req.word[30:0]} + i_req.diff;

    always_comb begin
        w  = i_req.word;
        st = arp_pkg::ST_OK;
        case (i_req.kind)
            arp_pkg::KIND_PC24, arp_pkg::KIND_CALL,
            arp_pkg::KIND_JUMP24, arp_pkg::KIND_PLT32: begin
                w  = arm_word;
                st = arm_status;
            end
            arp_pkg::KIND_THM_PC22, arp_pkg::KIND_THM_JUMP24: begin
                // Undefined weak references leave the branch alone.
                if (!i_req.weak_undefined) begin
                    w  = thm_word;
                    st = thm_status;
                end
            end
            arp_pkg::KIND_MOVT, arp_pkg::KIND_MOVW: begin
                w = i_req.word + arm_mov_imm;
            end
            arp_pkg::KIND_THM_MOVT: begin
                w = i_req.word | thm_mov_imm;
            end
            arp_pkg::KIND_THM_MOVW: begin
                w = i_req.word + thm_mov_imm;
            end
            arp_pkg::KIND_PREL31: begin
                if (prel[31] != prel[30]) begin
                    st = arp_pkg::ST_RANGE;
                end else begin
                    w = {i_req.word[31], prel[30:0]};
                end
            end
            arp_pkg::KIND_ABS32: begin
                w = i_req.word + i_req.target;
            end
            arp_pkg::KIND_REL32: begin
                w = i_req.word + i_req.diff;
            end
            arp_pkg::KIND_GOTPC: begin
                w = i_req.word + i_cfg.got_base - i_req.place;
            end
            arp_pkg::KIND_GOTOFF: begin
                w = i_req.word + i_req.target - i_cfg.got_base;
            end
            arp_pkg::KIND_GOT32: begin
                w = i_req.word + i_req.got_disp;
            end
            arp_pkg::KIND_NONE, arp_pkg::KIND_COPY: begin
                w = i_req.word;
            end
            arp_pkg::KIND_V4BX: begin
                if ((i_req.word & arp_pkg::V4BX_MASK) == arp_pkg::V4BX_MATCH) begin
                    w = i_req.word ^ arp_pkg::V4BX_BX ^ arp_pkg::V4BX_MOV_PC;
                end
            end
            arp_pkg::KIND_GLOB_DAT, arp_pkg::KIND_JUMP_SLOT: begin
                w = i_req.target;
            end
            default: begin
                st = arp_pkg::ST_UNKNOWN;
            end
        endcase
    end

    // Any error hands back the original word.
    assign o_new_word = (st == arp_pkg::ST_OK) ? w : i_req.word;
    assign o_status   = st;

endmodule

`default_nettype wire

@@ design/arp_checker.sv @@
// Port-level checker for the ARM relocation patcher, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module arp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_new_word,
    input wire logic [1:0]  o_status
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_new_word) && $stable(o_status)))
        else $error("result payload changed while stalled");

    // Requests are only held off when a result is waiting and blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled without a blocked result");

    // Reset empties the pipeline's result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind arm_relocation_patcher arp_checker u_arp_checker (.*);

`default_nettype wire
